// ===== rtl/core/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion macros shared by the ticket arbiter RTL; empty under synthesis.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
`define TQA_ASSERT(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) \
        else $error("assertion failed");
`define TQA_ASSERT_NEVER(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) !(prop)) \
        else $error("forbidden condition seen");
`else
`define TQA_ASSERT(lbl, clk, rstn, prop)
`define TQA_ASSERT_NEVER(lbl, clk, rstn, prop)
`endif

`endif

// ===== rtl/core/tqa_pkg.sv =====
// ----------------------------------------------------------------------------
// tqa_pkg
// Widths, codes and types shared by the two-class ticket queue arbiter.
// ----------------------------------------------------------------------------
package tqa_pkg;

    localparam int TICKET_W        = 16;
    localparam int AGE_W           = 7;
    localparam int BURST_W         = 4;
    localparam int STATUS_W        = 3;
    localparam int CFG_DATA_W      = 7;
    localparam int CFG_IDX_W       = 1;
    localparam int DEF_QUEUE_DEPTH = 16;

    localparam logic [AGE_W-1:0]   RESET_ELDERLY_AGE    = 7'd60;
    localparam logic [BURST_W-1:0] RESET_PRIORITY_BURST = 4'd3;
    localparam logic [BURST_W-1:0] RUN_MAX              = 4'd15;

    localparam logic [CFG_IDX_W-1:0] CFG_ELDERLY_AGE    = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_PRIORITY_BURST = 1'b1;

    localparam logic OP_ISSUE = 1'b0;
    localparam logic OP_CALL  = 1'b1;

    localparam logic CLASS_COMMON   = 1'b0;
    localparam logic CLASS_PRIORITY = 1'b1;

    localparam logic [STATUS_W-1:0] ST_ISSUED       = 3'd0;
    localparam logic [STATUS_W-1:0] ST_PRIORITY     = 3'd1;
    localparam logic [STATUS_W-1:0] ST_BURST_COMMON = 3'd2;
    localparam logic [STATUS_W-1:0] ST_COMMON       = 3'd3;
    localparam logic [STATUS_W-1:0] ST_EMPTY        = 3'd4;
    localparam logic [STATUS_W-1:0] ST_FULL         = 3'd5;

    // classified request handed from front to back
    typedef struct packed {
        logic call;
        logic prio;
    } cmd_t;

endpackage

// ===== rtl/core/tqa_ram.sv =====
// ----------------------------------------------------------------------------
// tqa_ram
// Generic simple dual-port RAM, one write port, one registered read port.
// ----------------------------------------------------------------------------
module tqa_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== rtl/core/tqa_front.sv =====
// ----------------------------------------------------------------------------
// tqa_front
// Accepts request items, classifies them and buffers them in a two-entry
// command queue toward the back end.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module tqa_front (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      s_valid,
    output logic                      s_ready,
    input  logic                      s_op,
    input  logic [tqa_pkg::AGE_W-1:0] s_age,
    input  logic [tqa_pkg::AGE_W-1:0] elderly_age,
    output logic                      cmd_valid,
    input  logic                      cmd_ready,
    output tqa_pkg::cmd_t             cmd
);
    import tqa_pkg::*;

    cmd_t       q_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] cnt_reg;
    logic [1:0] cnt_next;
    logic       push;
    logic       pop;
    cmd_t       new_cmd;

    always_comb begin
        s_ready      = (cnt_reg != 2'd2);
        cmd_valid    = (cnt_reg != 2'd0);
        cmd          = q_reg[rd_ptr_reg];
        push         = s_valid && s_ready;
        pop          = cmd_valid && cmd_ready;
        new_cmd.call = (s_op == OP_CALL);
        new_cmd.prio = (s_age >= elderly_age);
        case ({push, pop})
            2'b10:   cnt_next = cnt_reg + 2'd1;
            2'b01:   cnt_next = cnt_reg - 2'd1;
            default: cnt_next = cnt_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end else begin
            if (push) begin
                q_reg[wr_ptr_reg] <= new_cmd;
                wr_ptr_reg        <= ~wr_ptr_reg;
            end
            if (pop) begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            cnt_reg <= cnt_next;
        end
    end

    `TQA_ASSERT_NEVER(a_cnt_range, aclk, aresetn, cnt_reg == 2'd3)
    `TQA_ASSERT(a_ptr_match, aclk, aresetn, (cnt_reg != 2'd1) || (wr_ptr_reg != rd_ptr_reg))
    `TQA_ASSERT(a_even_ptrs, aclk, aresetn, (cnt_reg == 2'd1) || (wr_ptr_reg == rd_ptr_reg))

endmodule

// ===== rtl/core/tqa_back.sv =====
// ----------------------------------------------------------------------------
// tqa_back
// Executes issue and call commands against the two ticket queues and holds
// the result item in an output register.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module tqa_back #(
    parameter int QUEUE_DEPTH = tqa_pkg::DEF_QUEUE_DEPTH
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         cmd_valid,
    output logic                         cmd_ready,
    input  tqa_pkg::cmd_t                cmd,
    input  logic [tqa_pkg::BURST_W-1:0]  priority_burst,
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic [tqa_pkg::STATUS_W-1:0] m_status,
    output logic                         m_ticket_class,
    output logic [tqa_pkg::TICKET_W-1:0] m_ticket_number
);
    import tqa_pkg::*;

    localparam int AW    = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic {S_IDLE, S_READ} state_t;

    state_t              state_reg;
    logic                out_valid_reg;
    logic [STATUS_W-1:0] out_status_reg;
    logic                out_class_reg;
    logic [TICKET_W-1:0] out_number_reg;
    logic                rd_sel_reg;

    logic [AW-1:0]       p_head_reg, p_tail_reg, c_head_reg, c_tail_reg;
    logic [CNT_W-1:0]    p_count_reg, c_count_reg;
    logic [TICKET_W-1:0] p_num_reg, c_num_reg;
    logic [BURST_W-1:0]  run_reg;

    logic                take;
    logic                p_full, c_full, p_nonempty, c_nonempty;
    logic                issue_full;
    logic [TICKET_W-1:0] issue_number;
    logic                burst_hit, pop_prio, pop_common;
    logic [STATUS_W-1:0] call_status;
    logic                p_wr_en, c_wr_en, p_rd_en, c_rd_en;
    logic [TICKET_W-1:0] p_rd_data, c_rd_data;

    function automatic logic [AW-1:0] next_ptr(input logic [AW-1:0] p);
        return (p == AW'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    always_comb begin
        cmd_ready    = (state_reg == S_IDLE) && (!out_valid_reg || m_ready);
        take         = cmd_valid && cmd_ready;
        p_full       = (p_count_reg == CNT_W'(QUEUE_DEPTH));
        c_full       = (c_count_reg == CNT_W'(QUEUE_DEPTH));
        p_nonempty   = (p_count_reg != '0);
        c_nonempty   = (c_count_reg != '0);
        issue_full   = cmd.prio ? p_full : c_full;
        issue_number = cmd.prio ? p_num_reg : c_num_reg;
        burst_hit    = (run_reg >= priority_burst) && c_nonempty;
        pop_prio     = cmd.call && !burst_hit && p_nonempty;
        pop_common   = cmd.call && (burst_hit || (!p_nonempty && c_nonempty));
        p_wr_en      = take && !cmd.call && cmd.prio && !p_full;
        c_wr_en      = take && !cmd.call && !cmd.prio && !c_full;
        p_rd_en      = take && pop_prio;
        c_rd_en      = take && pop_common;
        if (burst_hit) begin
            call_status = ST_BURST_COMMON;
        end else if (p_nonempty) begin
            call_status = ST_PRIORITY;
        end else if (c_nonempty) begin
            call_status = ST_COMMON;
        end else begin
            call_status = ST_EMPTY;
        end
    end

    tqa_ram #(.WIDTH(TICKET_W), .DEPTH(QUEUE_DEPTH)) u_prio_ram (
        .aclk    (aclk),
        .wr_en   (p_wr_en),
        .wr_addr (p_tail_reg),
        .wr_data (p_num_reg),
        .rd_en   (p_rd_en),
        .rd_addr (p_head_reg),
        .rd_data (p_rd_data)
    );

    tqa_ram #(.WIDTH(TICKET_W), .DEPTH(QUEUE_DEPTH)) u_common_ram (
        .aclk    (aclk),
        .wr_en   (c_wr_en),
        .wr_addr (c_tail_reg),
        .wr_data (c_num_reg),
        .rd_en   (c_rd_en),
        .rd_addr (c_head_reg),
        .rd_data (c_rd_data)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
            p_head_reg    <= '0;
            p_tail_reg    <= '0;
            c_head_reg    <= '0;
            c_tail_reg    <= '0;
            p_count_reg   <= '0;
            c_count_reg   <= '0;
            p_num_reg     <= TICKET_W'(1);
            c_num_reg     <= TICKET_W'(1);
            run_reg       <= '0;
        end else begin
            if (out_valid_reg && m_ready) begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE: begin
                    if (take) begin
                        if (!cmd.call) begin
                            out_valid_reg  <= 1'b1;
                            out_status_reg <= issue_full ? ST_FULL : ST_ISSUED;
                            out_class_reg  <= cmd.prio ? CLASS_PRIORITY : CLASS_COMMON;
                            out_number_reg <= issue_full ? '0 : issue_number;
                            if (p_wr_en) begin
                                p_tail_reg  <= next_ptr(p_tail_reg);
                                p_count_reg <= p_count_reg + 1'b1;
                                p_num_reg   <= p_num_reg + 1'b1;
                            end
                            if (c_wr_en) begin
                                c_tail_reg  <= next_ptr(c_tail_reg);
                                c_count_reg <= c_count_reg + 1'b1;
                                c_num_reg   <= c_num_reg + 1'b1;
                            end
                        end else if (pop_prio) begin
                            p_head_reg     <= next_ptr(p_head_reg);
                            p_count_reg    <= p_count_reg - 1'b1;
                            run_reg        <= (run_reg == RUN_MAX) ? run_reg : run_reg + 1'b1;
                            out_status_reg <= call_status;
                            out_class_reg  <= CLASS_PRIORITY;
                            rd_sel_reg     <= CLASS_PRIORITY;
                            state_reg      <= S_READ;
                        end else if (pop_common) begin
                            c_head_reg     <= next_ptr(c_head_reg);
                            c_count_reg    <= c_count_reg - 1'b1;
                            run_reg        <= '0;
                            out_status_reg <= call_status;
                            out_class_reg  <= CLASS_COMMON;
                            rd_sel_reg     <= CLASS_COMMON;
                            state_reg      <= S_READ;
                        end else begin
                            out_valid_reg  <= 1'b1;
                            out_status_reg <= ST_EMPTY;
                            out_class_reg  <= CLASS_COMMON;
                            out_number_reg <= '0;
                        end
                    end
                end
                S_READ: begin
                    out_valid_reg  <= 1'b1;
                    out_number_reg <= (rd_sel_reg == CLASS_PRIORITY) ? p_rd_data : c_rd_data;
                    state_reg      <= S_IDLE;
                end
                default: begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign m_valid         = out_valid_reg;
    assign m_status        = out_status_reg;
    assign m_ticket_class  = out_class_reg;
    assign m_ticket_number = out_number_reg;

    `TQA_ASSERT(a_p_count_max, aclk, aresetn, p_count_reg <= CNT_W'(QUEUE_DEPTH))
    `TQA_ASSERT(a_p_empty_ptrs, aclk, aresetn, (p_count_reg != '0) || (p_head_reg == p_tail_reg))
    `TQA_ASSERT(a_c_empty_ptrs, aclk, aresetn, (c_count_reg != '0) || (c_head_reg == c_tail_reg))
    `TQA_ASSERT(a_read_slot, aclk, aresetn, (state_reg == S_READ) |-> !out_valid_reg)
    `TQA_ASSERT(a_read_done, aclk, aresetn, (state_reg == S_READ) |=> out_valid_reg)

endmodule

// ===== rtl/core/two_class_ticket_queue_arbiter.sv =====
// ----------------------------------------------------------------------------
// two_class_ticket_queue_arbiter
// Two ticket queues, priority and common, with age-based issue and a
// burst-limited call arbiter.
// ----------------------------------------------------------------------------
// Requests enter a front end that classifies them (issue by age against
// elderly_age, or call) and holds up to two of them in a command queue, so
// the input keeps accepting while a result waits on m_ready. The back end
// takes one command at a time: an issue, an empty call or a full-queue issue
// is answered straight from the idle state; a call that serves a ticket
// passes through the read state, since the ticket number comes out of the
// queue RAM through its registered read port. Queue RAM needs no clearing
// after reset; only written entries are ever read. The user must write the
// configuration registers through cfg_wr_en / cfg_index / cfg_wdata only
// while the block is idle; the block itself does not enforce this.
`include "assert_macros.svh"

module two_class_ticket_queue_arbiter #(
    parameter int QUEUE_DEPTH = tqa_pkg::DEF_QUEUE_DEPTH
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  logic                           s_op,
    input  logic [tqa_pkg::AGE_W-1:0]      s_age,
    output logic                           m_valid,
    input  logic                           m_ready,
    output logic [tqa_pkg::STATUS_W-1:0]   m_status,
    output logic                           m_ticket_class,
    output logic [tqa_pkg::TICKET_W-1:0]   m_ticket_number,
    input  logic                           cfg_wr_en,
    input  logic [tqa_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [tqa_pkg::CFG_DATA_W-1:0] cfg_wdata
);
    import tqa_pkg::*;

    logic [AGE_W-1:0]   elderly_age_reg;
    logic [BURST_W-1:0] priority_burst_reg;
    logic               cmd_valid;
    logic               cmd_ready;
    cmd_t               cmd;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            elderly_age_reg    <= RESET_ELDERLY_AGE;
            priority_burst_reg <= RESET_PRIORITY_BURST;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                CFG_ELDERLY_AGE:    elderly_age_reg    <= cfg_wdata[AGE_W-1:0];
                CFG_PRIORITY_BURST: priority_burst_reg <= cfg_wdata[BURST_W-1:0];
                default: begin
                end
            endcase
        end
    end

    tqa_front u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_op        (s_op),
        .s_age       (s_age),
        .elderly_age (elderly_age_reg),
        .cmd_valid   (cmd_valid),
        .cmd_ready   (cmd_ready),
        .cmd         (cmd)
    );

    tqa_back #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_back (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cmd_valid       (cmd_valid),
        .cmd_ready       (cmd_ready),
        .cmd             (cmd),
        .priority_burst  (priority_burst_reg),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_status        (m_status),
        .m_ticket_class  (m_ticket_class),
        .m_ticket_number (m_ticket_number)
    );

    `TQA_ASSERT(a_out_hold, aclk, aresetn, (m_valid && !m_ready) |=> m_valid)
    `TQA_ASSERT(a_payload_hold, aclk, aresetn, (m_valid && !m_ready) |=> $stable(m_ticket_number))
    `TQA_ASSERT_NEVER(a_status_range, aclk, aresetn, m_valid && (m_status > ST_FULL))

endmodule

// ===== verif/two_class_ticket_queue_arbiter_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// two_class_ticket_queue_arbiter_tb
// Self-checking bench for the two-class ticket queue arbiter.
// A short table of directed requests runs first: empty call, both classes at
// the age threshold, a priority queue filled to overflow and a served burst.
// Random issue and call traffic follows under several register settings,
// including the extremes and a zero threshold and zero burst.
// Each result is checked against its table entry or a predictor with its
// own queues and counters. Both sides of the handshake idle at random.
// ----------------------------------------------------------------------------
module two_class_ticket_queue_arbiter_tb;

    import tqa_pkg::*;

    localparam int QDEPTH = DEF_QUEUE_DEPTH;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic                cls;
        logic [TICKET_W-1:0] number;
    } ticket_resp_t;

    typedef struct packed {
        logic         op;
        logic [AGE_W-1:0] age;
        logic [4:0]   reps;
        logic         typed;
        ticket_resp_t resp;
    } stim_row_t;

    logic                  aclk            = 1'b0;
    logic                  aresetn         = 1'b0;
    logic                  s_valid         = 1'b0;
    logic                  s_ready;
    logic                  s_op            = OP_ISSUE;
    logic [AGE_W-1:0]      s_age           = '0;
    logic                  m_valid;
    logic                  m_ready         = 1'b0;
    logic [STATUS_W-1:0]   m_status;
    logic                  m_ticket_class;
    logic [TICKET_W-1:0]   m_ticket_number;
    logic                  cfg_wr_en       = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index       = CFG_ELDERLY_AGE;
    logic [CFG_DATA_W-1:0] cfg_wdata       = '0;

    // predictor state
    logic [TICKET_W-1:0] prio_tickets [$];
    logic [TICKET_W-1:0] common_tickets [$];
    logic [TICKET_W-1:0] next_prio_no   = 16'd1;
    logic [TICKET_W-1:0] next_common_no = 16'd1;
    logic [BURST_W-1:0]  prio_streak    = '0;
    logic [AGE_W-1:0]    cfg_age_limit  = RESET_ELDERLY_AGE;
    logic [BURST_W-1:0]  cfg_burst      = RESET_PRIORITY_BURST;

    ticket_resp_t due_resp [$];
    ticket_resp_t want;
    stim_row_t    directed_rows [0:8];

    bit idle_en = 1'b1;
    int items_sent      = 0;
    int results_checked = 0;
    int reg_writes      = 0;
    int bad_items       = 0;
    int status_hits [0:7] = '{default: 0};

    two_class_ticket_queue_arbiter #(
        .QUEUE_DEPTH(QDEPTH)
    ) dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_op           (s_op),
        .s_age          (s_age),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_status       (m_status),
        .m_ticket_class (m_ticket_class),
        .m_ticket_number(m_ticket_number),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_index      (cfg_index),
        .cfg_wdata      (cfg_wdata)
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    function automatic ticket_resp_t ticket_response(input logic op,
                                                     input logic [AGE_W-1:0] age);
        ticket_resp_t r;
        logic         prio;
        r.status = ST_EMPTY;
        r.cls    = CLASS_COMMON;
        r.number = '0;
        if (op == OP_ISSUE) begin
            prio  = (age >= cfg_age_limit);
            r.cls = prio ? CLASS_PRIORITY : CLASS_COMMON;
            r.status = ST_FULL;
            if (prio && prio_tickets.size() < QDEPTH) begin
                prio_tickets.push_back(next_prio_no);
                r.status = ST_ISSUED;
                r.number = next_prio_no;
                next_prio_no = next_prio_no + 1'b1;
            end else if (!prio && common_tickets.size() < QDEPTH) begin
                common_tickets.push_back(next_common_no);
                r.status = ST_ISSUED;
                r.number = next_common_no;
                next_common_no = next_common_no + 1'b1;
            end
        end else if (prio_streak >= cfg_burst && common_tickets.size() != 0) begin
            r.status = ST_BURST_COMMON;
            r.number = common_tickets.pop_front();
            prio_streak = '0;
        end else if (prio_tickets.size() != 0) begin
            r.status = ST_PRIORITY;
            r.cls    = CLASS_PRIORITY;
            r.number = prio_tickets.pop_front();
            if (prio_streak != RUN_MAX)
                prio_streak = prio_streak + 1'b1;
        end else if (common_tickets.size() != 0) begin
            r.status = ST_COMMON;
            r.number = common_tickets.pop_front();
            prio_streak = '0;
        end
        return r;
    endfunction

    function automatic logic [AGE_W-1:0] pick_age();
        logic [AGE_W-1:0] a;
        case ($urandom_range(4))
            0: a = '0;
            1: a = '1;
            2: a = cfg_age_limit;
            3: a = cfg_age_limit - 1'b1;
            default: a = AGE_W'($urandom_range((1 << AGE_W) - 1));
        endcase
        return a;
    endfunction

    task automatic send_item(input logic op, input logic [AGE_W-1:0] age,
                             input logic typed, input ticket_resp_t fixed);
        ticket_resp_t pred;
        @(negedge aclk);
        while (idle_en && $urandom_range(99) < 25) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_op    <= op;
        s_age   <= age;
        do @(posedge aclk); while (!s_ready);
        pred = ticket_response(op, age);
        due_resp.push_back(typed ? fixed : pred);
        items_sent++;
    endtask

    task automatic settle();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (due_resp.size() != 0)
            @(negedge aclk);
        repeat (4) @(negedge aclk);
    endtask

    task automatic set_config(input logic [AGE_W-1:0] age, input logic [BURST_W-1:0] burst);
        cfg_wr_en <= 1'b1;
        cfg_index <= CFG_ELDERLY_AGE;
        cfg_wdata <= age;
        @(negedge aclk);
        cfg_index <= CFG_PRIORITY_BURST;
        cfg_wdata <= {{(CFG_DATA_W-BURST_W){1'b0}}, burst};
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
        cfg_age_limit = age;
        cfg_burst     = burst;
        reg_writes += 2;
    endtask

    // segments lean toward issues, toward calls, or mix both
    task automatic run_random(input int n);
        int left;
        int seg;
        int issue_pct;
        left = n;
        while (left > 0) begin
            seg = $urandom_range(30, 5);
            case ($urandom_range(2))
                0: issue_pct = 85;
                1: issue_pct = 15;
                default: issue_pct = 50;
            endcase
            for (int k = 0; k < seg && left > 0; k++) begin
                if ($urandom_range(99) < issue_pct)
                    send_item(OP_ISSUE, pick_age(), 1'b0, '0);
                else
                    send_item(OP_CALL, AGE_W'($urandom_range((1 << AGE_W) - 1)),
                              1'b0, '0);
                left--;
            end
        end
    endtask

    always @(negedge aclk)
        m_ready <= !idle_en || ($urandom_range(99) >= 25);

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            results_checked++;
            status_hits[m_status]++;
            if (due_resp.size() == 0) begin
                bad_items++;
                if (bad_items <= 10)
                    $display("unexpected item at %0t: status %0d class %0d number %0d",
                             $time, m_status, m_ticket_class, m_ticket_number);
            end else begin
                want = due_resp.pop_front();
                if (m_status !== want.status || m_ticket_class !== want.cls ||
                    m_ticket_number !== want.number) begin
                    bad_items++;
                    if (bad_items <= 10)
                        $display("mismatch at %0t: status %0d/%0d class %0d/%0d number %0d/%0d",
                                 $time, want.status, m_status, want.cls, m_ticket_class,
                                 want.number, m_ticket_number);
                end
            end
        end
    end

    initial begin
        #(20_000_000);
        $display("two_class_ticket_queue_arbiter verification failed");
        $finish;
    end

    initial begin
        directed_rows = '{
            '{OP_CALL,  7'd0,   5'd1,  1'b1, '{ST_EMPTY,  CLASS_COMMON,   16'd0}},
            '{OP_ISSUE, 7'd127, 5'd1,  1'b1, '{ST_ISSUED, CLASS_PRIORITY, 16'd1}},
            '{OP_ISSUE, 7'd0,   5'd1,  1'b1, '{ST_ISSUED, CLASS_COMMON,   16'd1}},
            '{OP_ISSUE, 7'd60,  5'd1,  1'b1, '{ST_ISSUED, CLASS_PRIORITY, 16'd2}},
            '{OP_ISSUE, 7'd59,  5'd1,  1'b1, '{ST_ISSUED, CLASS_COMMON,   16'd2}},
            '{OP_ISSUE, 7'd85,  5'd14, 1'b0, '{ST_ISSUED, CLASS_PRIORITY, 16'd0}},
            '{OP_ISSUE, 7'd127, 5'd1,  1'b1, '{ST_FULL,   CLASS_PRIORITY, 16'd0}},
            '{OP_CALL,  7'd0,   5'd3,  1'b0, '{ST_EMPTY,  CLASS_COMMON,   16'd0}},
            '{OP_CALL,  7'd127, 5'd2,  1'b0, '{ST_EMPTY,  CLASS_COMMON,   16'd0}}
        };
        repeat (8) @(negedge aclk);
        aresetn <= 1'b1;
        settle();

        for (int i = 0; i < 9; i++)
            for (int r = 0; r < directed_rows[i].reps; r++)
                send_item(directed_rows[i].op, directed_rows[i].age,
                          directed_rows[i].typed, directed_rows[i].resp);

        settle();
        set_config(7'd1, 4'd1);
        run_random(150);

        settle();
        set_config(7'd127, 4'd15);
        run_random(75);
        settle();
        run_random(75);

        settle();
        set_config(7'd0, 4'd0);
        run_random(100);

        settle();
        set_config(AGE_W'($urandom_range(127, 1)), BURST_W'($urandom_range(15, 1)));
        idle_en = 1'b0;
        run_random(150);
        idle_en = 1'b1;

        settle();
        set_config(RESET_ELDERLY_AGE, RESET_PRIORITY_BURST);
        run_random(200);

        settle();
        repeat (12) @(negedge aclk);

        $display("sent %0d items, checked %0d results, %0d register writes, %0d mismatches",
                 items_sent, results_checked, reg_writes, bad_items);
        $display("issued %0d, priority %0d, burst common %0d, common %0d, empty %0d, full %0d",
                 status_hits[ST_ISSUED], status_hits[ST_PRIORITY],
                 status_hits[ST_BURST_COMMON], status_hits[ST_COMMON],
                 status_hits[ST_EMPTY], status_hits[ST_FULL]);
        if (bad_items == 0 && due_resp.size() == 0)
            $display("two_class_ticket_queue_arbiter verification clean");
        else
            $display("two_class_ticket_queue_arbiter verification failed");
        $finish;
    end

endmodule

// ===== sim.f =====
+incdir+rtl/core
rtl/core/tqa_pkg.sv
rtl/core/tqa_ram.sv
rtl/core/tqa_front.sv
rtl/core/tqa_back.sv
rtl/core/two_class_ticket_queue_arbiter.sv
verif/two_class_ticket_queue_arbiter_tb.sv
